// File: sv/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CHK_SAME(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CHK_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/clas_pkg.sv
// Types and constants of the cable lock actuator sequencer.
package clas_pkg;

  typedef enum logic [1:0] {
    LT_DISABLED = 2'd0,
    LT_SOLENOID = 2'd1,
    LT_MOTOR    = 2'd2
  } lock_type_e;

  typedef enum logic [1:0] {
    CFG_LOCK_TYPE   = 2'd0,
    CFG_PULSE_TICKS = 2'd1,
    CFG_OFF_TICKS   = 2'd2,
    CFG_RETRY_TICKS = 2'd3
  } cfg_idx_e;

  // Pin pair {A, B}.
  typedef enum logic [1:0] {
    PINS_LOCK   = 2'b01,
    PINS_UNLOCK = 2'b10,
    PINS_OFF    = 2'b11
  } pins_e;

  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned TICK_W     = 12;
  localparam int unsigned ELAPSED_W  = 16;

  localparam logic [1:0]           RST_LOCK_TYPE   = 2'd0;
  localparam logic [TICK_W-1:0]    RST_PULSE_TICKS = 12'd600;
  localparam logic [TICK_W-1:0]    RST_OFF_TICKS   = 12'd100;
  localparam logic [ELAPSED_W-1:0] RST_RETRY_TICKS = 16'd5000;

  typedef struct packed {
    logic [1:0]           lock_type;
    logic [TICK_W-1:0]    pulse_ticks;
    logic [TICK_W-1:0]    off_ticks;
    logic [ELAPSED_W-1:0] retry_ticks;
  } cfg_t;

  typedef struct packed {
    logic lock_request;
    logic unlock_request;
    logic sense_level;
  } in_t;

  typedef struct packed {
    logic drive_a;
    logic drive_b;
    logic unlock_busy;
    logic lock_busy;
  } out_t;

endpackage

// File: sv/clas_in_if.sv
// Input channel: request levels and sense pin.
interface clas_in_if;
  logic valid;
  logic ready;
  logic lock_request;
  logic unlock_request;
  logic sense_level;

  modport source(output valid, lock_request, unlock_request, sense_level, input ready);
  modport sink(input valid, lock_request, unlock_request, sense_level, output ready);
endinterface

// File: sv/clas_out_if.sv
// Output channel: actuator pin levels and job status.
interface clas_out_if;
  logic valid;
  logic ready;
  logic drive_a;
  logic drive_b;
  logic unlock_busy;
  logic lock_busy;

  modport source(output valid, drive_a, drive_b, unlock_busy, lock_busy, input ready);
  modport sink(input valid, drive_a, drive_b, unlock_busy, lock_busy, output ready);
endinterface

// File: sv/clas_cfg_regs.sv
// Configuration register file.
module clas_cfg_regs (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  clas_pkg::cfg_idx_e                  cfg_idx_i,
  input  logic [clas_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  output clas_pkg::cfg_t                      cfg_o
);
  import clas_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_LOCK_TYPE:   cfg_d.lock_type   = cfg_data_i[1:0];
        CFG_PULSE_TICKS: cfg_d.pulse_ticks = cfg_data_i[TICK_W-1:0];
        CFG_OFF_TICKS:   cfg_d.off_ticks   = cfg_data_i[TICK_W-1:0];
        CFG_RETRY_TICKS: cfg_d.retry_ticks = cfg_data_i[ELAPSED_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.lock_type   <= RST_LOCK_TYPE;
      cfg_q.pulse_ticks <= RST_PULSE_TICKS;
      cfg_q.off_ticks   <= RST_OFF_TICKS;
      cfg_q.retry_ticks <= RST_RETRY_TICKS;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;
endmodule

// File: sv/clas_in_stage.sv
// Input register that takes one beat per cycle while it is empty or its beat is being taken.
module clas_in_stage (
  input  logic           clk_i,
  input  logic           rst_ni,
  clas_in_if.sink        in_i,
  input  logic           take_i,
  output logic           valid_o,
  output clas_pkg::in_t  data_o
);
  import clas_pkg::*;

  logic valid_q, valid_d;
  in_t  data_q;
  logic accept;

  assign in_i.ready = !valid_q || take_i;
  assign accept     = in_i.valid && in_i.ready;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      data_q.lock_request   <= in_i.lock_request;
      data_q.unlock_request <= in_i.unlock_request;
      data_q.sense_level    <= in_i.sense_level;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;
endmodule

// File: sv/clas_core.sv
// Job state and per-tick sequencing logic.
module clas_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  clas_pkg::cfg_t  cfg_i,
  input  logic            step_i,
  input  clas_pkg::in_t   data_i,
  output clas_pkg::out_t  result_o
);
  import clas_pkg::*;

  typedef struct packed {
    logic                 armed;
    logic [ELAPSED_W-1:0] elapsed;
    pins_e                pins;
  } job_t;

  // One tick of a running job.
  function automatic job_t run_job(logic [ELAPSED_W-1:0] e, cfg_t c, logic sense,
                                   logic finish, pins_e drive);
    job_t                 r;
    logic [TICK_W:0]      drive_off_end;
    logic                 bump;
    drive_off_end = {1'b0, c.pulse_ticks} + {1'b0, c.off_ticks};
    r.armed   = 1'b1;
    r.elapsed = e;
    r.pins    = PINS_OFF;
    bump      = 1'b1;
    if (e < {{(ELAPSED_W-TICK_W){1'b0}}, c.pulse_ticks}) begin
      r.pins = drive;
    end else if (e >= {{(ELAPSED_W-TICK_W-1){1'b0}}, drive_off_end}) begin
      if (sense == finish) begin
        r.armed = 1'b0;
        bump    = 1'b0;
      end else if (e > c.retry_ticks) begin
        r.elapsed = '0;
        bump      = 1'b0;
      end
    end
    if (bump && (e != {ELAPSED_W{1'b1}})) begin
      r.elapsed = e + ELAPSED_W'(1);
    end
    return r;
  endfunction

  logic                 u_armed_q, u_armed_d, l_armed_q, l_armed_d;
  logic [ELAPSED_W-1:0] u_el_q, u_el_d, l_el_q, l_el_d;
  logic                 prev_u_q, prev_l_q;
  pins_e                pins_q, pins_d;

  logic                 enabled, locked_level;
  logic                 u_arm, l_arm;
  logic [ELAPSED_W-1:0] u_el, l_el;
  job_t                 u_job, l_job;

  assign enabled      = (cfg_i.lock_type == LT_SOLENOID) || (cfg_i.lock_type == LT_MOTOR);
  assign locked_level = (cfg_i.lock_type == LT_MOTOR);

  always_comb begin
    // Sample request edges: rising arms and restarts, low drops.
    u_arm = u_armed_q;
    u_el  = u_el_q;
    if (data_i.unlock_request && !prev_u_q) begin
      u_arm = 1'b1;
      u_el  = '0;
    end else if (!data_i.unlock_request) begin
      u_arm = 1'b0;
    end
    l_arm = l_armed_q;
    l_el  = l_el_q;
    if (data_i.lock_request && !prev_l_q) begin
      l_arm = 1'b1;
      l_el  = '0;
    end else if (!data_i.lock_request) begin
      l_arm = 1'b0;
    end

    u_job = run_job(u_el, cfg_i, data_i.sense_level, !locked_level, PINS_UNLOCK);
    l_job = run_job(l_el, cfg_i, data_i.sense_level, locked_level, PINS_LOCK);

    u_armed_d = u_arm;
    l_armed_d = l_arm;
    u_el_d    = u_el;
    l_el_d    = l_el;
    pins_d    = pins_q;
    if (!enabled) begin
      u_armed_d = 1'b0;
      l_armed_d = 1'b0;
      u_el_d    = u_el_q;
      l_el_d    = l_el_q;
      pins_d    = PINS_OFF;
    end else if (u_arm) begin
      u_armed_d = u_job.armed;
      u_el_d    = u_job.elapsed;
      pins_d    = u_job.pins;
      if (l_arm) begin
        l_el_d = '0;
      end
    end else if (l_arm) begin
      l_armed_d = l_job.armed;
      l_el_d    = l_job.elapsed;
      pins_d    = l_job.pins;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      u_armed_q <= 1'b0;
      l_armed_q <= 1'b0;
      u_el_q    <= '0;
      l_el_q    <= '0;
      prev_u_q  <= 1'b0;
      prev_l_q  <= 1'b0;
      pins_q    <= PINS_OFF;
    end else if (step_i) begin
      u_armed_q <= u_armed_d;
      l_armed_q <= l_armed_d;
      u_el_q    <= u_el_d;
      l_el_q    <= l_el_d;
      prev_u_q  <= data_i.unlock_request;
      prev_l_q  <= data_i.lock_request;
      pins_q    <= pins_d;
    end
  end

  assign result_o.drive_a     = pins_d[1];
  assign result_o.drive_b     = pins_d[0];
  assign result_o.unlock_busy = u_armed_d;
  assign result_o.lock_busy   = l_armed_d;
endmodule

// File: sv/clas_out_stage.sv
// Result register that holds a beat until the sink takes it.
module clas_out_stage (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            load_i,
  input  clas_pkg::out_t  data_i,
  output logic            room_o,
  clas_out_if.source      out_o
);
  import clas_pkg::*;

  logic valid_q, valid_d;
  out_t data_q;

  assign room_o = !valid_q || out_o.ready;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= data_i;
    end
  end

  assign out_o.valid       = valid_q;
  assign out_o.drive_a     = data_q.drive_a;
  assign out_o.drive_b     = data_q.drive_b;
  assign out_o.unlock_busy = data_q.unlock_busy;
  assign out_o.lock_busy   = data_q.lock_busy;
endmodule

// File: sv/cable_lock_actuator_sequencer.sv
// An accepted beat waits in the input register and its result is loaded into the result register
// when the beat advances. One beat per cycle while the result register has room; the job state
// register closes its loop on each advance. While a result waits in the output register, the
// input register takes at most one more beat and then holds ready low until the result is taken.
// Reset (async, active low) clears both jobs, request history and valid flags,
// sets the pins off and loads the default configuration.
module cable_lock_actuator_sequencer (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  clas_pkg::cfg_idx_e               cfg_idx_i,
  input  logic [clas_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  clas_in_if.sink                          in_i,
  clas_out_if.source                       out_o
);
  import clas_pkg::*;

  cfg_t cfg;
  in_t  in_data;
  out_t result;
  logic in_valid, room, step;

  // Advance a beat when the result register can take it.
  assign step = in_valid && room;

  clas_cfg_regs u_cfg (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i, .cfg_o(cfg)
  );

  clas_in_stage u_in (
    .clk_i, .rst_ni, .in_i, .take_i(step), .valid_o(in_valid), .data_o(in_data)
  );

  clas_core u_core (
    .clk_i, .rst_ni, .cfg_i(cfg), .step_i(step), .data_i(in_data), .result_o(result)
  );

  clas_out_stage u_out (
    .clk_i, .rst_ni, .load_i(step), .data_i(result), .room_o(room), .out_o
  );
endmodule

// File: sv/clas_checker.sv
// Port-level checks on the sequencer and the bind that attaches them.
`include "assert_macros.svh"

module clas_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic drive_a_i,
  input logic drive_b_i,
  input logic unlock_busy_i,
  input logic lock_busy_i
);
  // Pins never drive both low.
  `CHK_SAME(a_no_short, clk_i, rst_ni, out_valid_i, (drive_a_i || drive_b_i), "both pins low")
  // A busy unlock job ran this tick, so the lock drive cannot show.
  `CHK_SAME(a_unlock_owns, clk_i, rst_ni, (out_valid_i && unlock_busy_i),
            !(!drive_a_i && drive_b_i), "lock drive while unlock busy")
  // A busy lock job alone means lock ran or unlock just finished.
  `CHK_SAME(a_lock_owns, clk_i, rst_ni, (out_valid_i && lock_busy_i && !unlock_busy_i),
            !(drive_a_i && !drive_b_i), "unlock drive while only lock busy")
  // Hold a stalled result beat.
  `CHK_NEXT(a_out_hold, clk_i, rst_ni, (out_valid_i && !out_ready_i),
            (out_valid_i && $stable(drive_a_i) && $stable(drive_b_i) &&
             $stable(unlock_busy_i) && $stable(lock_busy_i)), "stalled result changed")
endmodule

bind cable_lock_actuator_sequencer clas_checker u_clas_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .drive_a_i     (out_o.drive_a),
  .drive_b_i     (out_o.drive_b),
  .unlock_busy_i (out_o.unlock_busy),
  .lock_busy_i   (out_o.lock_busy)
);

// File: verif/tb_cable_lock_actuator_sequencer.sv
// Testbench for the cable lock actuator sequencer: directed table, then random request episodes.
module tb_cable_lock_actuator_sequencer;
  import clas_pkg::*;

  localparam int JOB_UNLOCK = 0;
  localparam int JOB_LOCK   = 1;

  localparam out_t ALL_OFF      = 4'b1100;
  localparam out_t LOCK_DRIVE   = 4'b0101;
  localparam out_t UNLOCK_DRIVE = 4'b1011;

  typedef struct {
    bit          is_write;
    cfg_idx_e    idx;
    logic [15:0] wdata;
    in_t         stim;
    int unsigned reps;
    bit          typed;
    out_t        want;
  } plan_row_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  cfg_idx_e              cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  clas_in_if  in_if ();
  clas_out_if out_if ();

  cable_lock_actuator_sequencer i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  // Register mirror and job state of the expected behavior.
  logic [1:0]           m_lock_type;
  logic [TICK_W-1:0]    m_pulse;
  logic [TICK_W-1:0]    m_off;
  logic [ELAPSED_W-1:0] m_retry;
  bit                   job_armed [2];
  logic [ELAPSED_W-1:0] job_count [2];
  bit                   prev_req  [2];
  pins_e                pin_state;

  out_t        awaited [$];
  plan_row_t   plan [$];
  int unsigned fail_count = 0;
  int unsigned items_sent = 0;
  int          burst_left = 0;
  int          hold_reqs  = 0;
  int          holds_done = 0;

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // One tick of a running job; returns whether the job stays armed.
  function automatic bit run_attempt(int j, pins_e drive_pins, logic sense, logic done_level);
    if (job_count[j] < m_pulse) begin
      pin_state = drive_pins;
    end else if (32'(job_count[j]) < 32'(m_pulse) + 32'(m_off)) begin
      pin_state = PINS_OFF;
    end else begin
      pin_state = PINS_OFF;
      if (sense == done_level) return 1'b0;
      if (job_count[j] > m_retry) begin
        job_count[j] = '0;
        return 1'b1;
      end
    end
    if (job_count[j] != '1) job_count[j] = job_count[j] + 1'b1;
    return 1'b1;
  endfunction

  function automatic out_t actuator_tick(in_t it);
    logic locked_level;
    out_t r;
    if (m_lock_type != LT_SOLENOID && m_lock_type != LT_MOTOR) begin
      job_armed[JOB_UNLOCK] = 1'b0;
      job_armed[JOB_LOCK]   = 1'b0;
      pin_state             = PINS_OFF;
    end else begin
      locked_level = (m_lock_type == LT_MOTOR);
      if (it.unlock_request && !prev_req[JOB_UNLOCK]) begin
        job_armed[JOB_UNLOCK] = 1'b1;
        job_count[JOB_UNLOCK] = '0;
      end else if (!it.unlock_request) begin
        job_armed[JOB_UNLOCK] = 1'b0;
      end
      if (it.lock_request && !prev_req[JOB_LOCK]) begin
        job_armed[JOB_LOCK] = 1'b1;
        job_count[JOB_LOCK] = '0;
      end else if (!it.lock_request) begin
        job_armed[JOB_LOCK] = 1'b0;
      end
      // Unlock wins; hold the lock count at zero behind it.
      if (job_armed[JOB_UNLOCK]) begin
        job_armed[JOB_UNLOCK] = run_attempt(JOB_UNLOCK, PINS_UNLOCK, it.sense_level,
                                            ~locked_level);
        if (job_armed[JOB_LOCK]) job_count[JOB_LOCK] = '0;
      end else if (job_armed[JOB_LOCK]) begin
        job_armed[JOB_LOCK] = run_attempt(JOB_LOCK, PINS_LOCK, it.sense_level, locked_level);
      end
    end
    prev_req[JOB_UNLOCK] = it.unlock_request;
    prev_req[JOB_LOCK]   = it.lock_request;
    r.drive_a     = pin_state[1];
    r.drive_b     = pin_state[0];
    r.unlock_busy = job_armed[JOB_UNLOCK];
    r.lock_busy   = job_armed[JOB_LOCK];
    return r;
  endfunction

  function automatic plan_row_t write_row(cfg_idx_e idx, logic [15:0] d);
    plan_row_t r;
    r.is_write = 1'b1;
    r.idx      = idx;
    r.wdata    = d;
    r.stim     = '0;
    r.reps     = 0;
    r.typed    = 1'b0;
    r.want     = '0;
    return r;
  endfunction

  function automatic plan_row_t tick_row(bit l, bit u, bit s, int unsigned reps, bit typed,
                                         out_t want);
    plan_row_t r;
    r.is_write            = 1'b0;
    r.idx                 = CFG_LOCK_TYPE;
    r.wdata               = '0;
    r.stim.lock_request   = l;
    r.stim.unlock_request = u;
    r.stim.sense_level    = s;
    r.reps                = reps;
    r.typed               = typed;
    r.want                = want;
    return r;
  endfunction

  // Offer one beat in bursts with idle gaps between them; predict on acceptance.
  task automatic offer(in_t it, bit typed, out_t want);
    out_t model;
    if (burst_left <= 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 7) == 0) ? 64 : $urandom_range(1, 16);
    end
    burst_left--;
    in_if.valid          <= 1'b1;
    in_if.lock_request   <= it.lock_request;
    in_if.unlock_request <= it.unlock_request;
    in_if.sense_level    <= it.sense_level;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    model = actuator_tick(it);
    awaited.push_back(typed ? want : model);
    items_sent++;
  endtask

  task automatic quiesce();
    in_if.valid <= 1'b0;
    while (awaited.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [15:0] d);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= d;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      CFG_LOCK_TYPE:   m_lock_type = d[1:0];
      CFG_PULSE_TICKS: m_pulse     = d[TICK_W-1:0];
      CFG_OFF_TICKS:   m_off       = d[TICK_W-1:0];
      CFG_RETRY_TICKS: m_retry     = d;
      default: ;
    endcase
  endtask

  task automatic shuffle_config();
    int unsigned r;
    logic [15:0] d;
    r = $urandom_range(0, 9);
    if (r < 4)       d = 16'(LT_SOLENOID);
    else if (r < 8)  d = 16'(LT_MOTOR);
    else if (r == 8) d = 16'(LT_DISABLED);
    else             d = 16'd3;
    write_reg(CFG_LOCK_TYPE, d);
    // Mostly short timings so jobs cycle through every phase; junk in the upper nibble.
    d = ($urandom_range(0, 15) == 0) ? 16'($urandom_range(0, 4095)) : 16'($urandom_range(0, 6));
    d[15:12] = 4'($urandom_range(0, 15));
    write_reg(CFG_PULSE_TICKS, d);
    d = ($urandom_range(0, 15) == 0) ? 16'($urandom_range(0, 4095)) : 16'($urandom_range(0, 5));
    d[15:12] = 4'($urandom_range(0, 15));
    write_reg(CFG_OFF_TICKS, d);
    d = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 65535))
                                    : 16'($urandom_range(0, 24));
    write_reg(CFG_RETRY_TICKS, d);
  endtask

  // Request episodes: a level held for a while with the sense pin reaching its target
  // at a random tick, then released; some episodes are plain noise.
  task automatic random_episodes(int unsigned count);
    int unsigned stop, kind, len, reach, a, b, k;
    logic        locked_lvl, target;
    in_t         it;
    stop = items_sent + count;
    while (items_sent < stop) begin
      kind       = $urandom_range(0, 9);
      len        = $urandom_range(1, 30);
      reach      = $urandom_range(0, len + 4);
      a          = $urandom_range(0, len - 1);
      b          = $urandom_range(a, len);
      locked_lvl = (m_lock_type == LT_MOTOR);
      for (k = 0; k < len; k++) begin
        it = in_t'(3'($urandom_range(0, 7)));
        if (kind < 8) begin
          it.lock_request   = (kind < 4) || (kind == 7);
          it.unlock_request = (kind >= 4 && kind < 7) || (kind == 7 && k >= a && k < b);
          target            = it.unlock_request ? ~locked_lvl : locked_lvl;
          it.sense_level    = (k >= reach) ? target : ~target;
          if ($urandom_range(0, 11) == 0) it.sense_level = ~it.sense_level;
        end
        offer(it, 1'b0, '0);
      end
      if (kind < 8) begin
        repeat ($urandom_range(1, 3)) begin
          it             = '0;
          it.sense_level = 1'($urandom_range(0, 1));
          offer(it, 1'b0, '0);
        end
      end
    end
  endtask

  function automatic void check_bit(string field, logic want, logic got);
    if (want !== got) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %b, got %b", $time, field, want, got);
    end
  endfunction

  always @(posedge clk_i) begin : watch_results
    out_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (awaited.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected beat, expected none, got %b%b%b%b", $time, out_if.drive_a,
                 out_if.drive_b, out_if.unlock_busy, out_if.lock_busy);
      end else begin
        want = awaited.pop_front();
        check_bit("drive_a", want.drive_a, out_if.drive_a);
        check_bit("drive_b", want.drive_b, out_if.drive_b);
        check_bit("unlock_busy", want.unlock_busy, out_if.unlock_busy);
        check_bit("lock_busy", want.lock_busy, out_if.lock_busy);
      end
    end
  end

  // Receiver: ready runs with short stalls, plus one long hold-off on request.
  initial begin : drain_side
    int n;
    out_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_reqs != holds_done) begin
        holds_done++;
        out_if.ready <= 1'b0;
        repeat (300) @(posedge clk_i);
      end else begin
        out_if.ready <= 1'b1;
        n = ($urandom_range(0, 5) == 0) ? 80 : $urandom_range(1, 10);
        while (n > 0 && hold_reqs == holds_done) begin
          @(posedge clk_i);
          n--;
        end
        if (hold_reqs == holds_done) begin
          out_if.ready <= 1'b0;
          repeat ($urandom_range(1, 3)) @(posedge clk_i);
        end
      end
    end
  end

  initial begin : stimulus
    int ph;
    rst_ni               <= 1'b0;
    cfg_we_i             <= 1'b0;
    cfg_idx_i            <= CFG_LOCK_TYPE;
    cfg_data_i           <= '0;
    in_if.valid          <= 1'b0;
    in_if.lock_request   <= 1'b0;
    in_if.unlock_request <= 1'b0;
    in_if.sense_level    <= 1'b0;
    m_lock_type = RST_LOCK_TYPE;
    m_pulse     = RST_PULSE_TICKS;
    m_off       = RST_OFF_TICKS;
    m_retry     = RST_RETRY_TICKS;
    foreach (job_armed[j]) begin
      job_armed[j] = 1'b0;
      job_count[j] = '0;
      prev_req[j]  = 1'b0;
    end
    pin_state = PINS_OFF;

    plan = '{
      tick_row(1, 1, 1, 1, 1, ALL_OFF),            // disabled after reset
      write_row(CFG_LOCK_TYPE, 16'(LT_SOLENOID)),
      tick_row(0, 1, 0, 1, 1, ALL_OFF),            // unlock held across disable: no edge
      tick_row(0, 0, 0, 1, 1, ALL_OFF),
      tick_row(1, 0, 1, 1, 1, LOCK_DRIVE),         // default pulse starts
      tick_row(1, 0, 1, 700, 0, '0),               // rest of pulse, off time, first sense
      tick_row(1, 0, 0, 1, 0, '0),                 // pin reads locked: finish
      write_row(CFG_PULSE_TICKS, 16'hF001),
      write_row(CFG_OFF_TICKS, 16'h0000),
      write_row(CFG_RETRY_TICKS, 16'h0000),
      tick_row(0, 0, 0, 1, 1, ALL_OFF),
      tick_row(1, 0, 1, 1, 1, LOCK_DRIVE),
      tick_row(1, 0, 1, 3, 0, '0),                 // immediate retries
      tick_row(1, 0, 0, 2, 0, '0),
      tick_row(1, 0, 0, 2, 1, ALL_OFF),            // held high after finish: no re-arm
      tick_row(0, 0, 0, 1, 1, ALL_OFF),
      tick_row(1, 1, 0, 1, 1, UNLOCK_DRIVE),       // both rise: unlock first
      tick_row(1, 1, 0, 3, 0, '0),
      tick_row(1, 1, 1, 4, 0, '0),                 // unlock done, lock takes over
      write_row(CFG_LOCK_TYPE, 16'(LT_MOTOR)),
      write_row(CFG_PULSE_TICKS, 16'h0FFF),
      write_row(CFG_OFF_TICKS, 16'h0FFF),
      write_row(CFG_RETRY_TICKS, 16'd60000),
      tick_row(0, 0, 1, 1, 1, ALL_OFF),
      tick_row(0, 1, 1, 3, 0, '0),
      tick_row(0, 1, 0, 1, 0, '0),
      tick_row(0, 0, 0, 1, 0, '0),
      write_row(CFG_LOCK_TYPE, 16'd3),             // unused code acts as disabled
      tick_row(1, 1, 1, 1, 1, ALL_OFF),
      write_row(CFG_LOCK_TYPE, 16'(LT_SOLENOID)),
      write_row(CFG_PULSE_TICKS, 16'h0000),
      write_row(CFG_OFF_TICKS, 16'h0000),
      write_row(CFG_RETRY_TICKS, 16'hFFFF),
      tick_row(0, 0, 1, 1, 1, ALL_OFF),
      tick_row(1, 0, 1, 20, 0, '0),                // senses at once, long retry time
      tick_row(0, 0, 1, 1, 1, ALL_OFF)
    };

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[k]) begin
      if (plan[k].is_write) begin
        quiesce();
        write_reg(plan[k].idx, plan[k].wdata);
      end else begin
        repeat (plan[k].reps) offer(plan[k].stim, plan[k].typed, plan[k].want);
      end
    end

    for (ph = 0; ph < 20; ph++) begin
      quiesce();
      shuffle_config();
      if (ph == 2) hold_reqs <= hold_reqs + 1;
      if (ph == 6) begin
        // Pause mid-phase until every result is back.
        random_episodes(6);
        quiesce();
        random_episodes(6);
      end else begin
        random_episodes(12);
      end
    end

    in_if.valid <= 1'b0;
    while (awaited.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (fail_count == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  initial begin : watchdog
    #(8 * 3_000_000);
    $display("FAIL");
    $finish;
  end

endmodule

// File: filelist.f
+incdir+sv
sv/clas_pkg.sv
sv/clas_in_if.sv
sv/clas_out_if.sv
sv/clas_cfg_regs.sv
sv/clas_in_stage.sv
sv/clas_core.sv
sv/clas_out_stage.sv
sv/cable_lock_actuator_sequencer.sv
sv/clas_checker.sv
verif/tb_cable_lock_actuator_sequencer.sv
